// File: design/mf5_pkg.sv
// ----------------------------------------------------------------------------
// mf5_pkg: shared types and constants for the 5x5 median filter
// geometry defaults, window constants and the front-to-back word type
// ----------------------------------------------------------------------------
package mf5_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT     = 4096;
   localparam int WIN            = 5;
   localparam int WIN_AREA       = 25;
   localparam int MED_RANK       = 12;
   localparam int LINES          = 4;
   localparam int CFG_W          = 13;
   localparam int POS_W          = 12;
   localparam int PIX_W          = 8;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // one classified word passed from the front to the back
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             emit;
      logic             last;
   } front_word_type;

   localparam int FW_W = $bits(front_word_type);

endpackage

// File: design/median_filter_5x5.sv
// ----------------------------------------------------------------------------
// median_filter_5x5: streaming 5x5 median filter
// raster-order 8-bit pixels in, median of each full window out
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  req     | req_valid/ready, req_pixel             | in
//  rsp     | rsp_valid/ready, median, col, row, end | out
//  csr     | csr_write, csr_index, csr_data         | in
//
//  one pixel per cycle sustained while rsp is not stalled; a result passes
//  through the front-to-back queue and then the registered back pipeline
//  the line buffer is one memory of MAX_WIDTH words holding four rows
//  synchronous active-high reset restarts the frame; no clearing pass
//  a stalled rsp holds the whole back pipeline; the queue absorbs the front
// ----------------------------------------------------------------------------
module median_filter_5x5 #(
   parameter int MAX_WIDTH = mf5_pkg::MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [mf5_pkg::CFG_W-1:0] csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mf5_pkg::PIX_W-1:0] req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mf5_pkg::PIX_W-1:0] rsp_median,
   output logic [mf5_pkg::POS_W-1:0] rsp_center_col,
   output logic [mf5_pkg::POS_W-1:0] rsp_center_row,
   output logic                      rsp_frame_end
);
   import mf5_pkg::*;

   // configuration registers
   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CFG_W-1:0] eff_w, eff_h;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:   width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamp to the supported range
   always_comb begin
      eff_w = width_ff;
      if (eff_w < 13'd5) eff_w = 13'd5;
      if (32'(eff_w) > MAX_WIDTH) eff_w = CFG_W'(MAX_WIDTH);
      eff_h = height_ff;
      if (eff_h < 13'd5) eff_h = 13'd5;
      if (32'(eff_h) > MAX_HEIGHT) eff_h = CFG_W'(MAX_HEIGHT);
   end

   // front to queue to back
   logic           f_valid, f_ready, q_valid, q_ready;
   front_word_type f_data, q_data;

   mf5_front u_front (
      .clock, .reset, .csr_write,
      .req_valid, .req_ready, .req_pixel,
      .eff_width(eff_w), .eff_height(eff_h),
      .fw_valid(f_valid), .fw_ready(f_ready), .fw_data(f_data)
   );

   mf5_fifo u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   mf5_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .rsp_valid, .rsp_ready, .rsp_median, .rsp_center_col,
      .rsp_center_row, .rsp_frame_end
   );

`ifndef ASSERT_OFF
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      eff_w >= 13'd5 && 32'(eff_w) <= MAX_WIDTH)
      else $error("clamped width out of range");
   a_h_range: assert property (@(posedge clock) disable iff (reset)
      eff_h >= 13'd5 && 32'(eff_h) <= MAX_HEIGHT)
      else $error("clamped height out of range");
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == 1'b0) |=> width_ff == $past(csr_data))
      else $error("width write lost");
`endif
endmodule

// File: design/mf5_front.sv
// ----------------------------------------------------------------------------
// mf5_front: input acceptance and frame position tracking
// tags each pixel with its column and row and whether it completes a window
// ----------------------------------------------------------------------------
module mf5_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mf5_pkg::PIX_W-1:0]     req_pixel,
   input  logic [mf5_pkg::CFG_W-1:0]     eff_width,
   input  logic [mf5_pkg::CFG_W-1:0]     eff_height,
   output logic                          fw_valid,
   input  logic                          fw_ready,
   output mf5_pkg::front_word_type       fw_data
);
   import mf5_pkg::*;

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             take, col_wrap, row_wrap;
   logic [CFG_W-1:0] col_nx, row_nx;

   assign req_ready = fw_ready;
   assign fw_valid  = req_valid;
   assign take      = req_valid & fw_ready;

   assign col_nx   = {1'b0, col_ff} + 13'd1;
   assign row_nx   = {1'b0, row_ff} + 13'd1;
   assign col_wrap = col_nx >= eff_width;
   assign row_wrap = row_nx >= eff_height;

   always_comb begin
      fw_data.pixel = req_pixel;
      fw_data.col   = col_ff;
      fw_data.row   = row_ff;
      fw_data.emit  = (col_ff >= 12'd4) && (row_ff >= 12'd4);
      fw_data.last  = col_wrap & row_wrap;
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_nx[POS_W-1:0];
         end else begin
            col_in = col_nx[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef ASSERT_OFF
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < eff_width || $past(csr_write))
      else $error("column out of range");
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> col_ff == '0 && row_ff == '0)
      else $error("config write did not restart frame");
   a_emit_pos: assert property (@(posedge clock) disable iff (reset)
      fw_data.emit |-> col_ff >= 12'd4 && row_ff >= 12'd4)
      else $error("emit outside valid window");
`endif
endmodule

// File: design/mf5_fifo.sv
// ----------------------------------------------------------------------------
// mf5_fifo: two-entry queue between front and back
// lets either side stall without losing a word
// ----------------------------------------------------------------------------
module mf5_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  mf5_pkg::front_word_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output mf5_pkg::front_word_type out_data
);
   import mf5_pkg::*;

   front_word_type mem_ff [2];
   logic           wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wp_ff != rp_ff))
      else $error("queue pointers inconsistent");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost a word");
`endif
endmodule

// File: design/mf5_back.sv
// ----------------------------------------------------------------------------
// mf5_back: line buffers, 5x5 window and pipelined median network
// one column per word; median by rank counting over registered stages
// ----------------------------------------------------------------------------
module mf5_back #(
   parameter int MAX_WIDTH = mf5_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  mf5_pkg::front_word_type       in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mf5_pkg::PIX_W-1:0]     rsp_median,
   output logic [mf5_pkg::POS_W-1:0]     rsp_center_col,
   output logic [mf5_pkg::POS_W-1:0]     rsp_center_row,
   output logic                          rsp_frame_end
);
   import mf5_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int NS = 5; // pipeline depth after accept

   // pipeline control: all stages advance together when output not blocked
   logic adv;
   logic [NS-1:0] v_ff, v_in;
   assign adv      = !(v_ff[NS-1] && rsp_valid && !rsp_ready) ;
   assign in_ready = adv;

   // stage 0: line buffer read (4 rows packed in one word)
   logic [LINES*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [LINES*PIX_W-1:0] rd_ff;
   logic [AW-1:0]          addr;
   logic [POS_W-1:0]       ccol;
   front_word_type         s0_ff;
   logic                   take;

   // consecutive words always sit on different columns (width >= 5), so
   // the read data needs no bypass of the pending write
   logic [LINES*PIX_W-1:0] rd_fwd;
   assign rd_fwd = rd_ff;

   assign take = in_valid & adv;
   assign ccol = (32'(in_data.col) < MAX_WIDTH) ? in_data.col : POS_W'(MAX_WIDTH - 1);
   assign addr = AW'(ccol);

   // read then shift down: write {old[2:0],px} needs read data, so the
   // write happens one stage later at the same address
   logic [AW-1:0] addr_ff;
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff   <= line_mem[addr];
         addr_ff <= addr;
         s0_ff   <= in_data;
      end
      if (adv && v_ff[0])
         line_mem[addr_ff] <= {rd_fwd[0 +: 3*PIX_W] , s0_ff.pixel};
   end

   // stage 1: shift window, column[0]=oldest
   logic [PIX_W-1:0] win_ff [WIN_AREA];
   front_word_type   s1_ff;
   logic [PIX_W-1:0] colv [WIN];
   always_comb begin
      for (int k = 0; k < LINES; k++)
         colv[LINES-1-k] = rd_fwd[k*PIX_W +: PIX_W];
      colv[LINES] = s0_ff.pixel;
   end
   always_ff @(posedge clock) begin
      if (adv && v_ff[0]) begin
         for (int r = 0; r < WIN; r++) begin
            for (int k = 0; k < WIN-1; k++)
               win_ff[r*WIN+k] <= win_ff[r*WIN+k+1];
            win_ff[r*WIN+WIN-1] <= colv[r];
         end
      end
      if (adv) s1_ff <= s0_ff;
   end

   // stage 2: pairwise comparisons, less-than with index tie-break
   logic [WIN_AREA-1:0] lt_ff [WIN_AREA];
   logic [PIX_W-1:0]    w2_ff [WIN_AREA];
   front_word_type      s2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < WIN_AREA; i++) begin
            w2_ff[i] <= win_ff[i];
            for (int j = 0; j < WIN_AREA; j++)
               lt_ff[i][j] <= (win_ff[j] < win_ff[i]) ||
                              (win_ff[j] == win_ff[i] && j < i);
         end
         s2_ff <= s1_ff;
      end
   end

   // stage 3: rank of each element
   logic [4:0]       rank_ff [WIN_AREA];
   logic [PIX_W-1:0] w3_ff [WIN_AREA];
   front_word_type   s3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < WIN_AREA; i++) begin
            rank_ff[i] <= 5'($countones(lt_ff[i]));
            w3_ff[i]   <= w2_ff[i];
         end
         s3_ff <= s2_ff;
      end
   end

   // stage 4: select rank 12
   logic [PIX_W-1:0] med_ff, med_in;
   front_word_type   s4_ff;
   always_comb begin
      med_in = '0;
      for (int i = 0; i < WIN_AREA; i++)
         if (rank_ff[i] == 5'(MED_RANK)) med_in = med_in | w3_ff[i];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         med_ff <= med_in;
         s4_ff  <= s3_ff;
      end
   end

   always_comb begin
      v_in = v_ff;
      if (adv) v_in = {v_ff[NS-2:0], take};
   end
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   // output: words that emit no result drain silently
   assign rsp_valid      = v_ff[NS-1] & s4_ff.emit;
   assign rsp_median     = med_ff;
   assign rsp_center_col = s4_ff.col - 12'd2;
   assign rsp_center_row = s4_ff.row - 12'd2;
   assign rsp_frame_end  = s4_ff.last;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_median))
      else $error("result changed while stalled");
   a_emit_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_col >= 12'd2 && rsp_center_row >= 12'd2)
      else $error("center within border");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved during stall");
`endif
endmodule

// File: dv/median_filter_5x5_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_5x5_tb: self-checking bench for the 5x5 median filter
// streams raster frames through the req channel under random idle and stall
// bursts, predicts each median with its own line buffer and window model,
// and checks every rsp word in order against the predicted queue
// ----------------------------------------------------------------------------
module median_filter_5x5_tb;
   import mf5_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic [PIX_W-1:0] median;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             frame_end;
   } median_word_type;

   logic                clock;
   logic                reset;
   logic                csr_write;
   csr_index_type       csr_index;
   logic [CFG_W-1:0]    csr_data;
   logic                req_valid;
   logic                req_ready;
   logic [PIX_W-1:0]    req_pixel;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PIX_W-1:0]    rsp_median;
   logic [POS_W-1:0]    rsp_center_col;
   logic [POS_W-1:0]    rsp_center_row;
   logic                rsp_frame_end;

   median_filter_5x5 dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_median     (rsp_median),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_frame_end  (rsp_frame_end)
   );

   // pixels waiting for the driver and medians waiting for the dut
   logic [PIX_W-1:0] pixel_queue[$];
   median_word_type  median_queue[$];

   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;      // no idling in the last part of the run
   bit  req_fired = 0;  // last rising edge took a req word
   int  req_gap = 0;
   int  rsp_stall = 0;

   // predictor state: four line buffers, the window and the frame position
   logic [PIX_W-1:0] line_buf[LINES][MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win_px[WIN][WIN];
   int               pos_col = 0;
   int               pos_row = 0;
   logic [CFG_W-1:0] cfg_width = WIDTH_RESET;
   logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;

   function automatic int clamp_geom(logic [CFG_W-1:0] v, int hi);
      int r;
      r = v;
      if (r < 5) r = 5;
      if (r > hi) r = hi;
      return r;
   endfunction

   // 13th smallest of the 25 window pixels
   function automatic logic [PIX_W-1:0] window_median();
      logic [PIX_W-1:0] s[WIN_AREA];
      logic [PIX_W-1:0] x;
      int j;
      for (int r = 0; r < WIN; r++)
         for (int k = 0; k < WIN; k++)
            s[r*WIN+k] = win_px[r][k];
      for (int i = 1; i < WIN_AREA; i++) begin
         x = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > x) begin
            s[j+1] = s[j];
            j--;
         end
         s[j+1] = x;
      end
      return s[MED_RANK];
   endfunction

   // advance the filter model by one pixel, queue a median when the window is full
   task automatic filter_pixel(logic [PIX_W-1:0] px);
      logic [PIX_W-1:0] column[WIN];
      median_word_type  m;
      int w, h;
      w = clamp_geom(cfg_width, MAX_WIDTH_DEF);
      h = clamp_geom(cfg_height, MAX_HEIGHT);
      // column[0] is the oldest row, column[4] the new pixel
      for (int k = 0; k < LINES; k++)
         column[LINES-1-k] = line_buf[k][pos_col];
      column[LINES] = px;
      for (int k = LINES - 1; k > 0; k--)
         line_buf[k][pos_col] = line_buf[k-1][pos_col];
      line_buf[0][pos_col] = px;
      for (int r = 0; r < WIN; r++) begin
         for (int k = 0; k < WIN - 1; k++)
            win_px[r][k] = win_px[r][k+1];
         win_px[r][WIN-1] = column[r];
      end
      if (pos_col >= 4 && pos_row >= 4) begin
         m.median    = window_median();
         m.col       = POS_W'(pos_col - 2);
         m.row       = POS_W'(pos_row - 2);
         m.frame_end = (pos_col + 1 >= w) && (pos_row + 1 >= h);
         median_queue.push_back(m);
      end
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
      end else begin
         pos_col = pos_col + 1;
      end
   endtask

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // req driver: holds a word until taken, idles in random bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel <= '0;
      end else if (!req_valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_pixel <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
               req_gap <= $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp back-pressure in random bursts
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 11) == 0)
            rsp_stall <= $urandom_range(1, 16);
      end
   end

   // monitor: tracks csr writes and taken pixels, checks every rsp word
   always @(posedge clock) begin
      median_word_type e;
      req_fired <= 1'b0;
      if (!reset) begin
         if (csr_write) begin
            if (csr_index == CSR_LINE_WIDTH)
               cfg_width = csr_data;
            else
               cfg_height = csr_data;
            pos_col = 0;
            pos_row = 0;
         end
         if (req_valid && req_ready) begin
            req_fired <= 1'b1;
            filter_pixel(req_pixel);
         end
         if (rsp_valid && rsp_ready) begin
            if (median_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected word median %0d col %0d row %0d end %0d", $time,
                        rsp_median, rsp_center_col, rsp_center_row, rsp_frame_end);
            end else begin
               e = median_queue.pop_front();
               if (rsp_median !== e.median) begin
                  errors++;
                  $display("%0t: median expected %0d actual %0d", $time, e.median, rsp_median);
               end
               if (rsp_center_col !== e.col) begin
                  errors++;
                  $display("%0t: center_col expected %0d actual %0d", $time, e.col,
                           rsp_center_col);
               end
               if (rsp_center_row !== e.row) begin
                  errors++;
                  $display("%0t: center_row expected %0d actual %0d", $time, e.row,
                           rsp_center_row);
               end
               if (rsp_frame_end !== e.frame_end) begin
                  errors++;
                  $display("%0t: frame_end expected %0d actual %0d", $time, e.frame_end,
                           rsp_frame_end);
               end
            end
         end
      end
   end

   // wait for the sender to drain and every median to arrive, then let the
   // pipeline settle since pixels on the border leave nothing to wait for
   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_valid || median_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_set(csr_index_type idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         pixel_queue.push_back(PIX_W'($urandom));
   endtask

   // stimulus
   initial begin
      int w, h, n;
      reset     <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_LINE_WIDTH;
      csr_data  <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: below-range geometry clamps to a 5x5 frame, two frames of one median each
      csr_set(CSR_LINE_WIDTH, '0);
      csr_set(CSR_FRAME_HEIGHT, 13'd3);
      for (int i = 0; i < 25; i++)
         pixel_queue.push_back((i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : PIX_W'(i * 37));
      for (int i = 0; i < 25; i++)
         pixel_queue.push_back(8'd255);
      wait_idle();

      // reset geometry of 640 wide, a partial first row
      csr_set(CSR_LINE_WIDTH, WIDTH_RESET);
      csr_set(CSR_FRAME_HEIGHT, HEIGHT_RESET);
      queue_random(30);
      wait_idle();

      // random small geometries, whole and partial frames
      for (int p = 0; p < 5; p++) begin
         w = $urandom_range(5, 12);
         h = $urandom_range(5, 9);
         if (p == 3) w = $urandom_range(0, 4);
         if (p == 4) h = $urandom_range(0, 4);
         csr_set(CSR_LINE_WIDTH, CFG_W'(w));
         csr_set(CSR_FRAME_HEIGHT, CFG_W'(h));
         w = (w < 5) ? 5 : w;
         h = (h < 5) ? 5 : h;
         n = w * h * $urandom_range(1, 2);
         if (p % 4 == 2) n = n - $urandom_range(1, w * 2);
         queue_random(n);
         wait_idle();
      end

      // over-range width clamps to the full line length; start of a row
      csr_set(CSR_LINE_WIDTH, 13'h1fff);
      csr_set(CSR_FRAME_HEIGHT, 13'd5);
      queue_random(30);
      wait_idle();

      // over-range height clamps to 4096 rows; rows past the usual height
      csr_set(CSR_LINE_WIDTH, 13'd5);
      csr_set(CSR_FRAME_HEIGHT, 13'h1fff);
      queue_random(5 * 10);
      wait_idle();

      // width exactly at the line length, partial row cut by a new setting
      csr_set(CSR_LINE_WIDTH, 13'd4096);
      queue_random(16);
      wait_idle();

      // last part: no idling on either side
      quiet = 1;
      csr_set(CSR_LINE_WIDTH, 13'd7);
      csr_set(CSR_FRAME_HEIGHT, 13'd6);
      queue_random(7 * 6 * 2);
      wait_idle();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: median_filter_5x5.f
design/mf5_pkg.sv
design/mf5_front.sv
design/mf5_fifo.sv
design/mf5_back.sv
design/median_filter_5x5.sv
dv/median_filter_5x5_tb.sv
